// ===== rtl/chr_pkg.sv =====
// Package for the hash ring block: word types, kind and status codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package chr_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	// Fixed field widths.
	localparam int HASH_W  = 64;
	localparam int OWNER_W = 8;
	localparam int PCNT_W  = 7;

	// Request word.
	typedef struct packed {
		logic [1:0]         kind;
		logic [HASH_W-1:0]  point_hash;
		logic [OWNER_W-1:0] server_id;
	} req_word_t;

	// Response word.
	typedef struct packed {
		logic [OWNER_W-1:0] owner_id;
		logic [1:0]         status;
		logic [PCNT_W-1:0]  point_count;
	} rsp_word_t;

	// Memory read address source.
	typedef enum logic [1:0] {
		RD_MID  = 2'd0,
		RD_POS  = 2'd1,
		RD_DOWN = 2'd2,
		RD_UP   = 2'd3
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       cmp_upd;
		logic       wr_new;
		logic       wr_shift;
		logic       idx_init_used;
		logic       idx_init_lo;
		logic       idx_dec;
		logic       idx_inc;
		logic       used_inc;
		logic       used_dec;
		logic       res_set;
		logic [1:0] res_status;
		logic       res_owner;
		logic       rsp_load;
	} chr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] kind;
		logic       lo_lt_hi;
		logic       hit;
		logic       full;
		logic       used_zero;
		logic       idx_at_lo;
		logic       idx_last;
		logic       out_free;
	} chr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/chr_datapath.sv =====
// Datapath of the hash ring: sorted point memory, search bounds, shift
// index, point count and the response register. Uses chr_pkg.
`default_nettype none

module chr_datapath import chr_pkg::*; #(
	parameter int RING_DEPTH  = 64,
	parameter int SERVER_BITS = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_word_t req,
	input  wire chr_cmd_t  cmd,
	output chr_sts_t       sts,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);

	typedef struct packed {
		logic [HASH_W-1:0]      hash;
		logic [SERVER_BITS-1:0] owner;
	} entry_t;

	entry_t                 mem [RING_DEPTH];
	entry_t                 rdata_q;
	logic [1:0]             kind_q;
	logic [HASH_W-1:0]      hash_q;
	logic [SERVER_BITS-1:0] sid_q;
	logic [CW-1:0]          lo_q, hi_q, mid_q, idx_q, used_q;
	logic [CW-1:0]          mid, rd_full;
	logic [AW-1:0]          rd_addr, wr_addr;
	entry_t                 wr_data;
	logic                   wr_en;
	logic [1:0]             res_status_q;
	logic [SERVER_BITS-1:0] res_owner_q;
	logic                   rsp_valid_q;
	rsp_word_t              rsp_q;

	// Midpoint of the current search window.
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Read address selection.
	always_comb begin
		unique case (cmd.rd_sel)
			RD_MID:  rd_full = mid;
			RD_POS:  rd_full = (lo_q < used_q) ? lo_q : '0;
			RD_DOWN: rd_full = idx_q - CW'(1);
			RD_UP:   rd_full = idx_q + CW'(1);
			default: rd_full = mid;
		endcase
	end
	assign rd_addr = rd_full[AW-1:0];

	// Write port: a new entry goes at the lower bound, a shifted one at the index.
	assign wr_en   = cmd.wr_new | cmd.wr_shift;
	assign wr_addr = cmd.wr_new ? lo_q[AW-1:0] : idx_q[AW-1:0];
	assign wr_data = cmd.wr_new ? entry_t'({hash_q, sid_q}) : rdata_q;

	// Point memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Item latch, search window and shift index.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			hash_q <= req.point_hash;
			sid_q  <= SERVER_BITS'(req.server_id);
			lo_q   <= '0;
			hi_q   <= used_q;
		end else if (cmd.cmp_upd) begin
			if (rdata_q.hash < hash_q) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.rd_en && cmd.rd_sel == RD_MID) begin
			mid_q <= mid;
		end
		if (cmd.idx_init_used) begin
			idx_q <= used_q;
		end else if (cmd.idx_init_lo) begin
			idx_q <= lo_q;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - CW'(1);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_owner_q  <= cmd.res_owner ? rdata_q.owner : '0;
		end
	end

	// Point count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.used_inc) begin
			used_q <= used_q + CW'(1);
		end else if (cmd.used_dec) begin
			used_q <= used_q - CW'(1);
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.owner_id    <= OWNER_W'(res_owner_q);
			rsp_q.status      <= res_status_q;
			rsp_q.point_count <= PCNT_W'(used_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status toward the controller.
	always_comb begin
		sts.kind      = kind_q;
		sts.lo_lt_hi  = lo_q < hi_q;
		sts.hit       = (lo_q < used_q) && (rdata_q.hash == hash_q);
		sts.full      = used_q >= CW'(RING_DEPTH);
		sts.used_zero = used_q == '0;
		sts.idx_at_lo = idx_q == lo_q;
		sts.idx_last  = (idx_q + CW'(1)) >= used_q;
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	// The count never passes the ring depth.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(RING_DEPTH))
		else $error("point count above ring depth");

	// The count only moves on an explicit step.
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> ($past(cmd.used_inc) || $past(cmd.used_dec)))
		else $error("point count changed without a step");

	// A new response is never loaded over one still waiting.
	a_rsp_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("response overwritten");

endmodule

`default_nettype wire

// ===== rtl/chr_ctrl.sv =====
// Controller of the hash ring: sequences the binary search, the entry
// shifts and the response. Uses chr_pkg.
`default_nettype none

module chr_ctrl import chr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire chr_sts_t sts,
	output chr_cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SRCH = 7'b0000010,
		S_CMP  = 7'b0000100,
		S_CHK  = 7'b0001000,
		S_SHRD = 7'b0010000,
		S_SHWR = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.rd_en = 1'b1;
				if (sts.lo_lt_hi) begin
					cmd.rd_sel = RD_MID;
					state_d    = S_CMP;
				end else begin
					cmd.rd_sel = RD_POS;
					state_d    = S_CHK;
				end
			end
			S_CMP: begin
				cmd.cmp_upd = 1'b1;
				state_d     = S_SRCH;
			end
			S_CHK: begin
				cmd.res_set    = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_DONE;
				unique case (sts.kind)
					KIND_INSERT: begin
						if (sts.hit) begin
							cmd.wr_new = 1'b1;
						end else if (sts.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.idx_init_used = 1'b1;
							state_d           = S_SHRD;
						end
					end
					KIND_DELETE: begin
						if (sts.hit) begin
							cmd.idx_init_lo = 1'b1;
							state_d         = S_SHRD;
						end else begin
							cmd.res_status = ST_ABSENT;
						end
					end
					KIND_LOOKUP: begin
						if (sts.used_zero) begin
							cmd.res_status = ST_EMPTY;
						end else begin
							cmd.res_owner = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_SHRD: begin
				if (sts.kind == KIND_INSERT) begin
					if (sts.idx_at_lo) begin
						cmd.wr_new   = 1'b1;
						cmd.used_inc = 1'b1;
						state_d      = S_DONE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_DOWN;
						state_d    = S_SHWR;
					end
				end else begin
					if (sts.idx_last) begin
						cmd.used_dec = 1'b1;
						state_d      = S_DONE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_UP;
						state_d    = S_SHWR;
					end
				end
			end
			S_SHWR: begin
				cmd.wr_shift = 1'b1;
				if (sts.kind == KIND_INSERT) begin
					cmd.idx_dec = 1'b1;
				end else begin
					cmd.idx_inc = 1'b1;
				end
				state_d = S_SHRD;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A shift never starts for a lookup.
	a_shift_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHRD) |-> (sts.kind == KIND_INSERT || sts.kind == KIND_DELETE))
		else $error("shift entered for a lookup");

	// A word taken at the input always starts a search.
	a_load_srch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_SRCH))
		else $error("accepted word did not start a search");

	// The count only steps at the end of a shift.
	a_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.used_inc || cmd.used_dec) |=> (state_q == S_DONE))
		else $error("count stepped outside a shift end");

endmodule

`default_nettype wire

// ===== rtl/consistent_hash_ring_top.sv =====
// Consistent hash ring lookup: top level joining controller and datapath.
// A lookup runs a binary search over the n points, each step a midpoint read (S_SRCH)
// and a compare (S_CMP), then checks the found entry (S_CHK) and queues the result.
// Insert and delete also move entries to keep the ring sorted, each move a read (S_SHRD) and a write (S_SHWR).
// One word is worked at a time; the input is taken again in the cycle after a result is queued.
// Reset clears the point count and handshake state; the point memory is not cleared.
`default_nettype none

module consistent_hash_ring_top import chr_pkg::*; #(
	parameter int RING_DEPTH  = 64,
	parameter int SERVER_BITS = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	chr_cmd_t cmd;
	chr_sts_t sts;

	// Sequencer.
	chr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and compare.
	chr_datapath #(
		.RING_DEPTH  (RING_DEPTH),
		.SERVER_BITS (SERVER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
